// ===== hdl/egcd_pkg.sv =====
// shared types and constants for the extended gcd solver
// no dependencies; imported by egcd_ctrl, egcd_dp, the top level and the testbench
`default_nettype none
package egcd_pkg;

    localparam int DataWidthDefault = 32;
    localparam int FieldWidth       = 32;
    localparam int WideWidth        = 64;
    localparam int PartWidth        = 63;
    localparam int StatusWidth      = 2;
    localparam int InDataWidth      = 3 * FieldWidth;
    localparam int OutDataWidth     = 224;

    typedef enum logic [StatusWidth-1:0] {
        STATUS_SOLVABLE = 2'd0,
        STATUS_NO_DIV   = 2'd1,
        STATUS_GCD_ZERO = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ESTART,
        ST_EDIV,
        ST_UPDATE,
        ST_FSTART,
        ST_FDIV,
        ST_FINAL,
        ST_ZERO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_mode;
        logic div_step;
        logic update;
        logic final_latch;
        logic zero_latch;
    } cmd_t;

    typedef struct packed {
        logic rc_zero;
        logic g_zero;
        logic div_last;
    } stat_t;

endpackage
`default_nettype wire

// ===== hdl/egcd_ctrl.sv =====
// sequencer for the euclid loop and the final divisibility check
// depends on egcd_pkg
`default_nettype none
module egcd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          out_free,
    output logic               emit,
    input  wire egcd_pkg::stat_t st,
    output egcd_pkg::cmd_t     cmd
);
    import egcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!st.rc_zero)     state_next = ST_ESTART;
                else if (st.g_zero)  state_next = ST_ZERO;
                else                 state_next = ST_FSTART;
            end
            ST_ESTART: state_next = ST_EDIV;
            ST_EDIV:   if (st.div_last) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CHECK;
            ST_FSTART: state_next = ST_FDIV;
            ST_FDIV:   if (st.div_last) state_next = ST_FINAL;
            ST_FINAL:  state_next = ST_DONE;
            ST_ZERO:   state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ESTART: cmd.div_start = 1'b1;
            ST_EDIV:   cmd.div_step = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_FSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = 1'b1;
            end
            ST_FDIV:   cmd.div_step = 1'b1;
            ST_FINAL:  cmd.final_latch = 1'b1;
            ST_ZERO:   cmd.zero_latch = 1'b1;
            ST_DONE:   emit = out_free;
            default:   cmd = '0;
        endcase
    end

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CHECK))
        else $error("request accepted but sequencer did not start");

    a_emit_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == ST_DONE) && out_free)
        else $error("result emitted outside done state");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDIV && st.div_last) |=> (state_reg == ST_UPDATE))
        else $error("division end not followed by update");

endmodule
`default_nettype wire

// ===== hdl/egcd_dp.sv =====
// datapath: remainders, bezout coefficients, bit-serial divider with
// shift-add product accumulators; depends on egcd_pkg
`default_nettype none
module egcd_dp #(
    parameter int DATA_WIDTH = egcd_pkg::DataWidthDefault
) (
    input  wire logic                               clk,
    input  wire logic [egcd_pkg::FieldWidth-1:0]    value_a,
    input  wire logic [egcd_pkg::FieldWidth-1:0]    value_b,
    input  wire logic [egcd_pkg::FieldWidth-1:0]    target_c,
    input  wire egcd_pkg::cmd_t                     cmd,
    output egcd_pkg::stat_t                         st,
    output logic [egcd_pkg::FieldWidth-1:0]         gcd_value,
    output logic [egcd_pkg::FieldWidth-1:0]         bezout_x,
    output logic [egcd_pkg::FieldWidth-1:0]         bezout_y,
    output logic [egcd_pkg::StatusWidth-1:0]        status,
    output logic [egcd_pkg::PartWidth-1:0]          particular_x,
    output logic [egcd_pkg::PartWidth-1:0]          particular_y
);
    import egcd_pkg::*;

    localparam int RW = DATA_WIDTH + 1;
    localparam int CW = $clog2(DATA_WIDTH);

    logic signed [RW-1:0]        rp_reg, rc_reg, c_reg;
    logic signed [WideWidth-1:0] xp_reg, yp_reg, xc_reg, yc_reg;
    logic [DATA_WIDTH-1:0]       num_reg, den_reg, rem_reg;
    logic [CW-1:0]               cnt_reg;
    logic [WideWidth-1:0]        accx_reg, accy_reg;
    logic                        qneg_reg, rneg_reg, mode_reg;
    logic [StatusWidth-1:0]      status_reg;
    logic [WideWidth-1:0]        px_reg, py_reg;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [RW-1:0] v);
        logic [RW-1:0] t;
        t = v[RW-1] ? -v : v;
        return t[DATA_WIDTH-1:0];
    endfunction

    // one restoring division step, quotient bit feeds both products
    logic [DATA_WIDTH:0]    rem_sh, rem_sub;
    logic                   qbit;
    logic [WideWidth-1:0]   mx, my, accx_step, accy_step;
    logic [RW-1:0]          rem_ext, r_signed;
    logic signed [WideWidth-1:0] xn, yn;
    logic [WideWidth-1:0]   g64;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[DATA_WIDTH-1]};
        qbit      = rem_sh >= {1'b0, den_reg};
        rem_sub   = rem_sh - {1'b0, den_reg};
        mx        = mode_reg ? xp_reg : xc_reg;
        my        = mode_reg ? yp_reg : yc_reg;
        accx_step = (accx_reg << 1) + (qbit ? mx : '0);
        accy_step = (accy_reg << 1) + (qbit ? my : '0);
        rem_ext   = {1'b0, rem_reg};
        r_signed  = rneg_reg ? -rem_ext : rem_ext;
        xn        = qneg_reg ? (xp_reg + accx_reg) : (xp_reg - accx_reg);
        yn        = qneg_reg ? (yp_reg + accy_reg) : (yp_reg - accy_reg);
        g64       = {{(WideWidth-RW){rp_reg[RW-1]}}, rp_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rp_reg <= {value_a[DATA_WIDTH-1], value_a[DATA_WIDTH-1:0]};
            rc_reg <= {value_b[DATA_WIDTH-1], value_b[DATA_WIDTH-1:0]};
            c_reg  <= {target_c[DATA_WIDTH-1], target_c[DATA_WIDTH-1:0]};
            xp_reg <= 64'sd1;
            yp_reg <= 64'sd0;
            xc_reg <= 64'sd0;
            yc_reg <= 64'sd1;
        end
        if (cmd.div_start)
        begin
            mode_reg <= cmd.div_mode;
            num_reg  <= cmd.div_mode ? mag(c_reg) : mag(rp_reg);
            den_reg  <= cmd.div_mode ? mag(rp_reg) : mag(rc_reg);
            qneg_reg <= cmd.div_mode ? (c_reg[RW-1] ^ rp_reg[RW-1])
                                     : (rp_reg[RW-1] ^ rc_reg[RW-1]);
            rneg_reg <= cmd.div_mode ? c_reg[RW-1] : rp_reg[RW-1];
            rem_reg  <= '0;
            cnt_reg  <= '0;
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= qbit ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            num_reg  <= num_reg << 1;
            accx_reg <= accx_step;
            accy_reg <= accy_step;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.update)
        begin
            rp_reg <= rc_reg;
            rc_reg <= r_signed;
            xp_reg <= xc_reg;
            yp_reg <= yc_reg;
            xc_reg <= xn;
            yc_reg <= yn;
        end
        if (cmd.final_latch)
        begin
            if (rem_reg != '0)
            begin
                status_reg <= STATUS_NO_DIV;
                px_reg     <= '0;
                py_reg     <= '0;
            end
            else
            begin
                status_reg <= STATUS_SOLVABLE;
                px_reg     <= qneg_reg ? -accx_reg : accx_reg;
                py_reg     <= qneg_reg ? -accy_reg : accy_reg;
            end
        end
        if (cmd.zero_latch)
        begin
            status_reg <= STATUS_GCD_ZERO;
            px_reg     <= '0;
            py_reg     <= '0;
        end
    end

    assign st.rc_zero   = (rc_reg == '0);
    assign st.g_zero    = (rp_reg == '0);
    assign st.div_last  = (cnt_reg == CW'(DATA_WIDTH - 1));

    assign gcd_value    = g64[FieldWidth-1:0];
    assign bezout_x     = xp_reg[FieldWidth-1:0];
    assign bezout_y     = yp_reg[FieldWidth-1:0];
    assign status       = status_reg;
    assign particular_x = px_reg[PartWidth-1:0];
    assign particular_y = py_reg[PartWidth-1:0];

endmodule
`default_nettype wire

// ===== hdl/extended_gcd_diophantine_solver.sv =====
// top level of the extended gcd solver for a*x + b*y = c
// depends on egcd_pkg, egcd_ctrl and egcd_dp
`default_nettype none
// One request (a, b, c) in, one result out. The block runs Euclid's algorithm
// with truncating division (quotient toward zero, remainder signed like the
// dividend), so the gcd may come out negative. Each Euclid step is one
// bit-serial division that also builds q*x and q*y by shift-add; after the
// last step one more division of c by the gcd forms the particular solution.
// A single shared divider serves every division. Status 0 means solvable,
// 1 means the gcd does not divide c, 2 means a = b = 0. A finished result
// waits in the output register while the next request is taken.
module extended_gcd_diophantine_solver #(
    parameter int DATA_WIDTH = egcd_pkg::DataWidthDefault
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // value_a, value_b, target_c from bit 0 up
    input  wire logic [egcd_pkg::InDataWidth-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // gcd_value, bezout_x, bezout_y, particular_x, particular_y, zero pad
    output logic [egcd_pkg::OutDataWidth-1:0]        m_tdata,
    // status
    output logic [egcd_pkg::StatusWidth-1:0]         m_tuser
);
    import egcd_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  emit;
    logic  out_free;

    logic [FieldWidth-1:0]  gcd_value, bezout_x, bezout_y;
    logic [StatusWidth-1:0] status;
    logic [PartWidth-1:0]   particular_x, particular_y;

    logic                    m_tvalid_reg;
    logic [OutDataWidth-1:0] m_tdata_reg;
    logic [StatusWidth-1:0]  m_tuser_reg;

    // output slot frees when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    egcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .st       (st),
        .cmd      (cmd)
    );

    egcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .value_a      (s_tdata[FieldWidth-1:0]),
        .value_b      (s_tdata[2*FieldWidth-1:FieldWidth]),
        .target_c     (s_tdata[3*FieldWidth-1:2*FieldWidth]),
        .cmd          (cmd),
        .st           (st),
        .gcd_value    (gcd_value),
        .bezout_x     (bezout_x),
        .bezout_y     (bezout_y),
        .status       (status),
        .particular_x (particular_x),
        .particular_y (particular_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload, loaded once per request
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= {2'b00, particular_y, particular_x,
                            bezout_y, bezout_x, gcd_value};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ===== verif/extended_gcd_diophantine_solver_tb.sv =====
// self-checking testbench for extended_gcd_diophantine_solver
// depends on egcd_pkg and the solver rtl; a built-in predictor or a hand-written answer checks every result
`default_nettype none
module extended_gcd_diophantine_solver_tb;
    import egcd_pkg::*;

    localparam int NumRandom   = 345;
    localparam int CalmItems   = 60;     // tail of the run with no idling
    localparam int HoldCycles  = 3000;   // long receiver hold-off
    localparam int StallLimit  = 20000;  // cycles with no transfer before giving up
    localparam int DrainCycles = 1700;   // wait after all results are back

    // one expected solution
    typedef struct {
        logic [31:0] gcd_value;
        logic [31:0] bezout_x;
        logic [31:0] bezout_y;
        status_t     status;
        logic [62:0] particular_x;
        logic [62:0] particular_y;
    } solution_t;

    // one directed row; has_exp marks rows with a hand-written answer
    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          has_exp;
        solution_t   exp;
    } directed_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutDataWidth-1:0] m_tdata;
    logic [StatusWidth-1:0]  m_tuser;

    solution_t pending_solutions[$];
    int        error_count;
    int        results_seen;
    bit        calm;            // set for the last part of the run
    bit        sender_done;

    extended_gcd_diophantine_solver #(.DATA_WIDTH(32)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // truncating extended euclid on 64-bit values, fields keep the low bits
    function automatic solution_t solve_diophantine(logic [31:0] a_raw, logic [31:0] b_raw,
                                                    logic [31:0] c_raw);
        longint    rem_prev, rem_cur, x_prev, y_prev, x_cur, y_cur;
        longint    quot, rem_next, x_next, y_next, rhs, factor;
        solution_t sol;
        rem_prev = longint'($signed(a_raw));
        rem_cur  = longint'($signed(b_raw));
        rhs      = longint'($signed(c_raw));
        x_prev = 1;
        y_prev = 0;
        x_cur  = 0;
        y_cur  = 1;
        while (rem_cur != 0)
        begin
            quot     = rem_prev / rem_cur;
            rem_next = rem_prev % rem_cur;
            x_next   = x_prev - quot * x_cur;
            y_next   = y_prev - quot * y_cur;
            rem_prev = rem_cur;
            rem_cur  = rem_next;
            x_prev   = x_cur;
            y_prev   = y_cur;
            x_cur    = x_next;
            y_cur    = y_next;
        end
        sol.gcd_value    = rem_prev[31:0];
        sol.bezout_x     = x_prev[31:0];
        sol.bezout_y     = y_prev[31:0];
        sol.particular_x = '0;
        sol.particular_y = '0;
        if (rem_prev == 0)
        begin
            sol.status = STATUS_GCD_ZERO;
        end
        else if (rhs % rem_prev != 0)
        begin
            sol.status = STATUS_NO_DIV;
        end
        else
        begin
            factor = rhs / rem_prev;
            x_next = x_prev * factor;
            y_next = y_prev * factor;
            sol.status       = STATUS_SOLVABLE;
            sol.particular_x = x_next[62:0];
            sol.particular_y = y_next[62:0];
        end
        return sol;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // offer one request, holding it until accepted; optional idle burst first
    task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                solution_t sol);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {c, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_solutions.push_back(sol);
        @(negedge clk);
    endtask

    // random operand, biased toward small values, extremes and the most negative code
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0001;
            3: return 32'h8000_0000;
            4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 1000) : -$urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    // sender: directed table, then random requests
    initial
    begin
        directed_row_t rows[$];
        directed_row_t row;
        solution_t     sol;
        logic [31:0]   a, b, c, scale;
        int            mode;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        sender_done = 1'b0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // both operands zero: gcd-zero status, no division
        row = '{32'd0, 32'd0, 32'd5, 1'b1,
                '{32'd0, 32'd1, 32'd0, STATUS_GCD_ZERO, 63'd0, 63'd0}};
        rows.push_back(row);
        // b zero: gcd is a, x = 1, y = 0
        row = '{32'd7, 32'd0, 32'd14, 1'b1,
                '{32'd7, 32'd1, 32'd0, STATUS_SOLVABLE, 63'd2, 63'd0}};
        rows.push_back(row);
        row = '{32'd7, 32'd0, 32'd3, 1'b1,
                '{32'd7, 32'd1, 32'd0, STATUS_NO_DIV, 63'd0, 63'd0}};
        rows.push_back(row);
        // a zero: one step swaps the operands
        row = '{32'd0, 32'd5, 32'd10, 1'b1,
                '{32'd5, 32'd0, 32'd1, STATUS_SOLVABLE, 63'd0, 63'd2}};
        rows.push_back(row);
        // predictor-checked rows: signs, extremes, most negative code
        row.has_exp = 1'b0;
        row.a = 32'd12;          row.b = 32'd18;          row.c = 32'd6;
        rows.push_back(row);
        row.a = -32'sd12;        row.b = 32'd18;          row.c = -32'sd30;
        rows.push_back(row);
        row.a = 32'd12;          row.b = -32'sd18;        row.c = 32'd7;
        rows.push_back(row);
        row.a = -32'sd35;        row.b = -32'sd21;        row.c = 32'd14;
        rows.push_back(row);
        row.a = 32'h7fff_ffff;   row.b = 32'h7fff_fffe;   row.c = 32'h7fff_ffff;
        rows.push_back(row);
        row.a = 32'h8000_0001;   row.b = 32'h7fff_ffff;   row.c = 32'h8000_0001;
        rows.push_back(row);
        row.a = 32'h8000_0001;   row.b = 32'h8000_0002;   row.c = 32'h8000_0001;
        rows.push_back(row);
        // fibonacci pair: longest chain of steps
        row.a = 32'd1836311903;  row.b = 32'd1134903170;  row.c = 32'h7fff_ffff;
        rows.push_back(row);
        row.a = 32'h8000_0000;   row.b = 32'd0;           row.c = 32'h8000_0000;
        rows.push_back(row);
        row.a = 32'h8000_0000;   row.b = 32'h8000_0000;   row.c = 32'h7fff_ffff;
        rows.push_back(row);
        row.a = 32'h8000_0000;   row.b = 32'h7fff_ffff;   row.c = 32'h8000_0000;
        rows.push_back(row);
        row.a = 32'd1;           row.b = 32'h8000_0000;   row.c = 32'h8000_0000;
        rows.push_back(row);
        row.a = 32'd0;           row.b = 32'hffff_ffff;   row.c = 32'h7fff_ffff;
        rows.push_back(row);
        row.a = 32'hffff_ffff;   row.b = 32'd1;           row.c = 32'd0;
        rows.push_back(row);
        row.a = 32'd0;           row.b = 32'd0;           row.c = 32'h8000_0000;
        rows.push_back(row);

        foreach (rows[i])
        begin
            sol = rows[i].has_exp ? rows[i].exp : solve_diophantine(rows[i].a, rows[i].b,
                                                                     rows[i].c);
            send_request(rows[i].a, rows[i].b, rows[i].c, sol);
        end

        for (int n = 0; n < NumRandom; n++)
        begin
            calm = (n >= NumRandom - CalmItems);
            // sender pause: let the block drain completely once
            if (n == NumRandom / 2)
            begin
                s_tvalid = 1'b0;
                while (pending_solutions.size() != 0)
                    @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            if (mode == 0)
            begin
                a = $urandom();
                b = $urandom();
                c = $urandom();
            end
            else if (mode == 1)
            begin
                // shared factor, c a multiple of it: mostly solvable
                scale = $urandom_range(1, 5000);
                a = scale * ($urandom_range(0, 40000) - 20000);
                b = scale * ($urandom_range(0, 40000) - 20000);
                c = scale * ($urandom_range(0, 40000) - 20000);
            end
            else
            begin
                a = pick_operand();
                b = pick_operand();
                c = pick_operand();
            end
            send_request(a, b, c, solve_diophantine(a, b, c));
        end
        s_tvalid    = 1'b0;
        sender_done = 1'b1;
    end

    // receiver: random stall bursts plus one long hold-off that backs up the block
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 60)
            begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // result checker against the oldest pending solution
    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_solutions.size() == 0)
            begin
                $display("result %0d arrived with nothing pending", results_seen);
                error_count++;
            end
            else
            begin
                want = pending_solutions.pop_front();
                // gcd, x, y, particular x, particular y from bit 0 up
                if (m_tdata[31:0] !== want.gcd_value)
                    report_mismatch("gcd_value", m_tdata[31:0], want.gcd_value);
                if (m_tdata[63:32] !== want.bezout_x)
                    report_mismatch("bezout_x", m_tdata[63:32], want.bezout_x);
                if (m_tdata[95:64] !== want.bezout_y)
                    report_mismatch("bezout_y", m_tdata[95:64], want.bezout_y);
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[158:96] !== want.particular_x)
                    report_mismatch("particular_x", m_tdata[158:96], want.particular_x);
                if (m_tdata[221:159] !== want.particular_y)
                    report_mismatch("particular_y", m_tdata[221:159], want.particular_y);
            end
            results_seen++;
        end
    end

    // watchdog: cycles without any transfer on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("extended_gcd_diophantine_solver_tb: done, errors");
        $finish;
    end

    // end of run: all requests in, all results back, then a short drain
    initial
    begin
        error_count  = 0;
        results_seen = 0;
        wait (sender_done);
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && pending_solutions.size() == 0)
            $display("extended_gcd_diophantine_solver_tb: done, clean");
        else
            $display("extended_gcd_diophantine_solver_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
